// ===== hw/rtl/tba_pkg.sv =====
// tba_pkg: shared constants, register codes and arithmetic helpers for the
// tinted bitmap alpha blend core. Depends on nothing; used by the core
// as tba_pkg::name.
`timescale 1ns / 1ps
`default_nettype none

package tba_pkg;

   // pixel and channel widths
   localparam int PixW   = 32;
   localparam int ByteW  = 8;
   localparam int ShiftW = 5;
   localparam int NumCh  = 3;   // red, green, blue

   // configuration port
   localparam int CsrIdxW = 4;

   typedef enum logic [CsrIdxW-1:0] {
      RegTintRed    = 4'd0,
      RegTintGreen  = 4'd1,
      RegTintBlue   = 4'd2,
      RegTintAlpha  = 4'd3,
      RegRedShift   = 4'd4,
      RegGreenShift = 4'd5,
      RegBlueShift  = 4'd6,
      RegAlphaShift = 4'd7
   } csr_index_type;

   // register values after reset
   localparam logic [ByteW-1:0]  TintReset       = 8'd255;
   localparam logic [ShiftW-1:0] RedShiftReset   = 5'd16;
   localparam logic [ShiftW-1:0] GreenShiftReset = 5'd8;
   localparam logic [ShiftW-1:0] BlueShiftReset  = 5'd0;
   localparam logic [ShiftW-1:0] AlphaShiftReset = 5'd24;

   // pipeline depth, accept to result register
   localparam int NumStages = 7;

   // full scale of a product of two bytes (255 * 255)
   localparam logic [15:0] BlendK = 16'd65025;

   // floor(x / BlendK) for any 32-bit x as (x * DivMul) >> DivShift;
   // the rounding error of DivMul stays below 2^(DivShift-32), which keeps it exact
   localparam int DivShift = 47;
   localparam int DivQW    = 17;
   localparam logic [31:0] DivMul =
      32'(((64'd1 << DivShift) + 64'(BlendK) - 64'd1) / 64'(BlendK));

   typedef logic [DivQW-1:0] div_q_type;

   function automatic div_q_type div_k(input logic [31:0] x);
      logic [63:0] prod;
      prod = {32'd0, x} * {32'd0, DivMul};
      return prod[DivShift+DivQW-1:DivShift];
   endfunction

   // byte of a 32-bit word at any bit position, bits above the word read as zero
   function automatic logic [ByteW-1:0] pick_byte(input logic [PixW-1:0] w,
                                                  input logic [ShiftW-1:0] sh);
      logic [PixW-1:0] t;
      t = w >> sh;
      return t[ByteW-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tinted_bitmap_alpha_blend_core.sv =====
// tinted_bitmap_alpha_blend_core: seven-stage source-over blender with tint and
// global opacity, ARGB8888 destination. Depends on tba_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Usage
// - req channel: one item is a source pixel and a destination pixel, taken when
//   req_valid and req_ready are both high.
// - rsp channel: one blended ARGB pixel per item, in order, held stable while
//   rsp_valid is high and rsp_ready is low.
// - csr channel: register index and 8-bit data; csr_ready is always high.
//   Indexes 0..3 are the red, green, blue and alpha tints, 4..7 the bit
//   positions of red, green, blue and alpha in the source pixel. Other indexes
//   are ignored; shift registers keep the low 5 bits of the data.
// - throughput is one item per cycle while the receiver takes results, set by the
//   seven-stage multiplier pipeline; rsp_valid follows the last stage register.
// - each stage loads whenever it is empty or its successor moves, so a stalled
//   receiver only stops the pipeline once all seven stages hold an item;
//   empty stages keep filling and req_ready stays high until then.
// - reset (synchronous) empties the pipeline and loads the default tints
//   (all 255) and shifts (red 16, green 8, blue 0, alpha 24).
module tinted_bitmap_alpha_blend_core (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_source_pixel,
   input  wire logic [31:0] req_dest_pixel,
   // result channel
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_blended_pixel,
   // configuration channel
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [3:0]  csr_index,
   input  wire logic [7:0]  csr_wdata
);

   localparam int NS = tba_pkg::NumStages;
   localparam int NC = tba_pkg::NumCh;

   // configuration registers
   logic [7:0] tint_ff   [NC];
   logic [7:0] tinta_ff;
   logic [4:0] shift_ff  [NC];
   logic [4:0] ashift_ff;

   assign csr_ready = 1'b1;

   // register writes, unknown indexes dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         tint_ff[0]  <= tba_pkg::TintReset;
         tint_ff[1]  <= tba_pkg::TintReset;
         tint_ff[2]  <= tba_pkg::TintReset;
         tinta_ff    <= tba_pkg::TintReset;
         shift_ff[0] <= tba_pkg::RedShiftReset;
         shift_ff[1] <= tba_pkg::GreenShiftReset;
         shift_ff[2] <= tba_pkg::BlueShiftReset;
         ashift_ff   <= tba_pkg::AlphaShiftReset;
      end else if (csr_valid && csr_ready) begin
         case (tba_pkg::csr_index_type'(csr_index))
            tba_pkg::RegTintRed:    tint_ff[0]  <= csr_wdata;
            tba_pkg::RegTintGreen:  tint_ff[1]  <= csr_wdata;
            tba_pkg::RegTintBlue:   tint_ff[2]  <= csr_wdata;
            tba_pkg::RegTintAlpha:  tinta_ff    <= csr_wdata;
            tba_pkg::RegRedShift:   shift_ff[0] <= csr_wdata[4:0];
            tba_pkg::RegGreenShift: shift_ff[1] <= csr_wdata[4:0];
            tba_pkg::RegBlueShift:  shift_ff[2] <= csr_wdata[4:0];
            tba_pkg::RegAlphaShift: ashift_ff   <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   // stage valid bits and load enables
   logic [NS-1:0] vld_ff;
   logic [NS-1:0] vld_in;
   logic [NS-1:0] en;

   always_comb begin
      en[NS-1] = !vld_ff[NS-1] || rsp_ready;
      for (int i = NS - 2; i >= 0; i--) begin
         en[i] = !vld_ff[i] || en[i+1];
      end
      vld_in[0] = req_valid;
      for (int i = 1; i < NS; i++) begin
         vld_in[i] = vld_ff[i-1];
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = vld_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < NS; i++) begin
            if (en[i]) vld_ff[i] <= vld_in[i];
         end
      end
   end

   // stage 1: byte extraction, source alpha weight, channel tint weight
   logic [7:0]  s1_sc_ff [NC];
   logic [7:0]  s1_dc_ff [NC];
   logic [15:0] s1_bc_ff [NC];
   logic [7:0]  s1_sa_ff;
   logic [7:0]  s1_da_ff;
   logic [15:0] s1_w_ff;
   logic [7:0]  s1_sc_in [NC];
   logic [7:0]  s1_dc_in [NC];
   logic [15:0] s1_bc_in [NC];
   logic [7:0]  s1_sa_in;
   logic [7:0]  s1_da_in;
   logic [15:0] s1_w_in;

   always_comb begin
      for (int c = 0; c < NC; c++) begin
         s1_sc_in[c] = tba_pkg::pick_byte(req_source_pixel, shift_ff[c]);
         s1_dc_in[c] = req_dest_pixel[8*(NC-1-c) +: 8];
         s1_bc_in[c] = 16'(tint_ff[c]) * 16'(tinta_ff);
      end
      s1_sa_in = tba_pkg::pick_byte(req_source_pixel, ashift_ff);
      s1_da_in = req_dest_pixel[31:24];
      s1_w_in  = 16'(s1_sa_in) * 16'(tinta_ff);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s1_sc_ff <= s1_sc_in;
         s1_dc_ff <= s1_dc_in;
         s1_bc_ff <= s1_bc_in;
         s1_sa_ff <= s1_sa_in;
         s1_da_ff <= s1_da_in;
         s1_w_ff  <= s1_w_in;
      end
   end

   // stage 2: weighted source, weighted destination, alpha numerator
   logic [23:0] s2_a_ff  [NC];
   logic [23:0] s2_qd_ff [NC];
   logic [15:0] s2_bc_ff [NC];
   logic [23:0] s2_an_ff;
   logic [23:0] s2_a_in  [NC];
   logic [23:0] s2_qd_in [NC];
   logic [23:0] s2_an_in;
   logic [15:0] s2_inv_w;
   logic [24:0] s2_an_sum;

   always_comb begin
      s2_inv_w = tba_pkg::BlendK - s1_w_ff;
      for (int c = 0; c < NC; c++) begin
         s2_a_in[c]  = 24'(s1_sc_ff[c]) * 24'(s1_w_ff);
         s2_qd_in[c] = 24'(s2_inv_w) * 24'(s1_dc_ff[c]);
      end
      s2_an_sum = 25'(24'(s1_sa_ff) * 24'(s1_w_ff)) + 25'(24'(s2_inv_w) * 24'(s1_da_ff));
      s2_an_in  = s2_an_sum[23:0];
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s2_a_ff  <= s2_a_in;
         s2_qd_ff <= s2_qd_in;
         s2_bc_ff <= s1_bc_ff;
         s2_an_ff <= s2_an_in;
      end
   end

   // stage 3: whole part of the weighted source, final alpha
   logic [7:0]  s3_aq_ff [NC];
   logic [23:0] s3_a_ff  [NC];
   logic [23:0] s3_qd_ff [NC];
   logic [15:0] s3_bc_ff [NC];
   logic [7:0]  s3_oa_ff;
   logic [7:0]  s3_aq_in [NC];
   logic [7:0]  s3_oa_in;
   tba_pkg::div_q_type s3_aq_full [NC];
   tba_pkg::div_q_type s3_oa_full;

   always_comb begin
      for (int c = 0; c < NC; c++) begin
         s3_aq_full[c] = tba_pkg::div_k(32'(s2_a_ff[c]));
         s3_aq_in[c]   = s3_aq_full[c][7:0];
      end
      s3_oa_full = tba_pkg::div_k(32'(s2_an_ff));
      s3_oa_in   = s3_oa_full[7:0];
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         s3_aq_ff <= s3_aq_in;
         s3_a_ff  <= s2_a_ff;
         s3_qd_ff <= s2_qd_ff;
         s3_bc_ff <= s2_bc_ff;
         s3_oa_ff <= s3_oa_in;
      end
   end

   // stage 4: remainder of the weighted source
   logic [15:0] s4_ar_ff [NC];
   logic [7:0]  s4_aq_ff [NC];
   logic [23:0] s4_qd_ff [NC];
   logic [15:0] s4_bc_ff [NC];
   logic [7:0]  s4_oa_ff;
   logic [15:0] s4_ar_in [NC];
   logic [23:0] s4_diff  [NC];

   always_comb begin
      for (int c = 0; c < NC; c++) begin
         s4_diff[c]  = s3_a_ff[c] - 24'(s3_aq_ff[c]) * 24'(tba_pkg::BlendK);
         s4_ar_in[c] = s4_diff[c][15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         s4_ar_ff <= s4_ar_in;
         s4_aq_ff <= s3_aq_ff;
         s4_qd_ff <= s3_qd_ff;
         s4_bc_ff <= s3_bc_ff;
         s4_oa_ff <= s3_oa_ff;
      end
   end

   // stage 5: both parts times the channel tint weight
   logic [31:0] s5_pr_ff [NC];
   logic [23:0] s5_pq_ff [NC];
   logic [23:0] s5_qd_ff [NC];
   logic [7:0]  s5_oa_ff;
   logic [31:0] s5_pr_in [NC];
   logic [23:0] s5_pq_in [NC];

   always_comb begin
      for (int c = 0; c < NC; c++) begin
         s5_pr_in[c] = 32'(s4_ar_ff[c]) * 32'(s4_bc_ff[c]);
         s5_pq_in[c] = 24'(s4_aq_ff[c]) * 24'(s4_bc_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         s5_pr_ff <= s5_pr_in;
         s5_pq_ff <= s5_pq_in;
         s5_qd_ff <= s4_qd_ff;
         s5_oa_ff <= s4_oa_ff;
      end
   end

   // stage 6: source term over full scale plus destination term
   logic [23:0] s6_t_ff  [NC];
   logic [7:0]  s6_oa_ff;
   logic [23:0] s6_t_in  [NC];
   tba_pkg::div_q_type s6_pk [NC];
   logic [24:0] s6_sum   [NC];

   always_comb begin
      for (int c = 0; c < NC; c++) begin
         s6_pk[c]   = tba_pkg::div_k(s5_pr_ff[c]);
         s6_sum[c]  = 25'(s5_pq_ff[c]) + 25'(s6_pk[c][15:0]) + 25'(s5_qd_ff[c]);
         s6_t_in[c] = s6_sum[c][23:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         s6_t_ff  <= s6_t_in;
         s6_oa_ff <= s5_oa_ff;
      end
   end

   // stage 7: final channel divide and ARGB packing
   logic [31:0] out_ff;
   logic [31:0] out_in;
   tba_pkg::div_q_type s7_oc [NC];

   always_comb begin
      out_in[31:24] = s6_oa_ff;
      for (int c = 0; c < NC; c++) begin
         s7_oc[c] = tba_pkg::div_k(32'(s6_t_ff[c]));
         out_in[8*(NC-1-c) +: 8] = s7_oc[c][7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[6]) begin
         out_ff <= out_in;
      end
   end

   assign rsp_blended_pixel = out_ff;

endmodule

`default_nettype wire
